// ----- rtl/core/asoc_pkg.sv -----
// ----------------------------------------------------------------------------
// asoc_pkg
// shared types and constants of the airspeed offset calibration core
// ----------------------------------------------------------------------------
package asoc_pkg;

    localparam int WINDOW_LEN_DEF  = 10;
    localparam int SKIP_COUNT_DEF  = 40;
    localparam int CALIB_COUNT_DEF = 60;

    localparam int SAMPLE_W = 16;
    localparam int SPEED_W  = 18;
    localparam int SCALE_W  = 10;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 32;
    localparam int REM_W    = 18;
    localparam int STEP_W   = 4;
    localparam int PROD_W   = SCALE_W + ROOT_W;
    localparam int FRAC_W   = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SCALE_W-1:0]  SPEED_SCALE_RST = 10'd461;
    localparam logic [SPEED_W-1:0]  SPEED_BIAS_RST  = 18'd0;
    localparam logic [SAMPLE_W-1:0] OFFSET_MIN_RST  = 16'd1550;
    localparam logic [SAMPLE_W-1:0] OFFSET_MAX_RST  = 16'd1750;

    typedef enum logic [1:0]
    {
        REG_SPEED_SCALE = 2'd0,
        REG_SPEED_BIAS  = 2'd1,
        REG_OFFSET_MIN  = 2'd2,
        REG_OFFSET_MAX  = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        logic                bus_idle;
        logic [SAMPLE_W-1:0] raw_sample;
    } sample_t;

    typedef struct packed
    {
        logic [SPEED_W-1:0] airspeed;
        logic               sample_ok;
        logic               calibrated;
    } result_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_CALIB,
        ST_OFFSET,
        ST_PREP,
        ST_SQRT,
        ST_MUL,
        ST_BIAS,
        ST_ACC,
        ST_AVG,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/core/asoc_ram.sv -----
// ----------------------------------------------------------------------------
// asoc_ram
// generic single-port-write, registered-read ram
// ----------------------------------------------------------------------------
module asoc_ram
#(
    parameter int WIDTH = 18,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/airspeed_offset_calib_sqrt_average_core.sv -----
// ----------------------------------------------------------------------------
// airspeed_offset_calib_sqrt_average_core
// pressure sample to airspeed with zero-offset calibration and moving average
// ----------------------------------------------------------------------------
//  channel   ports                                   direction
//  sample    sample_valid, sample_stall, sample      in
//  result    result_valid, result_stall, result      out
//  config    psel, penable, pwrite, paddr, pwdata,   apb slave
//            prdata, pready
//
//  one transaction at a time; a converted sample runs the 16-step square
//  root between accept and result (the calibrating sample also the offset
//  step), samples that skip the root do not, invalid samples go to output
//  the window lives in a ram with per-entry valid bits cleared at reset
//  a stalled result is held while the core waits; a new sample is taken
//  as soon as the previous result is in the output register
// ----------------------------------------------------------------------------
module airspeed_offset_calib_sqrt_average_core
#(
    parameter int WINDOW_LEN  = asoc_pkg::WINDOW_LEN_DEF,
    parameter int SKIP_COUNT  = asoc_pkg::SKIP_COUNT_DEF,
    parameter int CALIB_COUNT = asoc_pkg::CALIB_COUNT_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  asoc_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output asoc_pkg::result_t                   result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [asoc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [asoc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [asoc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int SW   = asoc_pkg::SAMPLE_W;
    localparam int VW   = asoc_pkg::SPEED_W;
    localparam int PW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TW   = $clog2(WINDOW_LEN * ((1 << VW) - 1) + 1);
    localparam int WSH  = TW + $clog2(WINDOW_LEN);
    localparam int WPW  = 2 * TW + 2;
    localparam longint WMUL_L = ((64'd1 << WSH) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam logic [TW+1:0] WMUL = (TW+2)'(WMUL_L);
    localparam int CSW  = $clog2(CALIB_COUNT * ((1 << SW) - 1) + 1);
    localparam int CSH  = CSW + $clog2(CALIB_COUNT);
    localparam int CPW  = 2 * CSW + 2;
    localparam longint CMUL_L = ((64'd1 << CSH) + CALIB_COUNT - 1) / CALIB_COUNT;
    localparam logic [CSW+1:0] CMUL = (CSW+2)'(CMUL_L);
    localparam int CDW  = $clog2(SKIP_COUNT + CALIB_COUNT + 1);
    localparam logic [CDW-1:0] CD_RST = CDW'(SKIP_COUNT + CALIB_COUNT);
    localparam logic [CDW-1:0] CD_SUM = CDW'(CALIB_COUNT);
    localparam logic [PW-1:0]  POS_LAST = PW'(WINDOW_LEN - 1);
    localparam logic [asoc_pkg::STEP_W-1:0] STEP_LAST = asoc_pkg::STEP_W'(asoc_pkg::ROOT_W - 1);

    asoc_pkg::state_t state_reg;
    asoc_pkg::state_t state_next;

    logic [asoc_pkg::SCALE_W-1:0] speed_scale_reg;
    logic [VW-1:0]                speed_bias_reg;
    logic [SW-1:0]                offset_min_reg;
    logic [SW-1:0]                offset_max_reg;

    logic [CDW-1:0]        countdown_reg;
    logic [CSW-1:0]        calib_sum_reg;
    logic [SW-1:0]         zero_offset_reg;
    logic                  offset_done_reg;
    logic [PW-1:0]         pos_reg;
    logic [TW-1:0]         total_reg;
    logic [WINDOW_LEN-1:0] win_valid_reg;

    asoc_pkg::result_t result_reg;
    logic              result_valid_reg;

    logic                              item_ok_reg;
    logic [SW-1:0]                     raw_reg;
    logic [CPW-1:0]                    cprod_reg;
    logic [asoc_pkg::RAD_W-1:0]        rad_reg;
    logic [asoc_pkg::REM_W-1:0]        rem_reg;
    logic [asoc_pkg::ROOT_W-1:0]       root_reg;
    logic [asoc_pkg::STEP_W-1:0]       step_reg;
    logic [asoc_pkg::PROD_W-1:0]       sprod_reg;
    logic [VW-1:0]                     speed_reg;
    logic [WPW-1:0]                    wprod_reg;

    logic                              accept;
    logic                              item_ok;
    logic                              cfg_write;
    asoc_pkg::reg_idx_t                cfg_idx;
    logic [CDW-1:0]                    cd_dec;
    logic                              calib_hit;
    logic [SW-1:0]                     mean;
    logic [SW-1:0]                     off_lo;
    logic [SW-1:0]                     off_cl;
    logic [asoc_pkg::REM_W+1:0]        rem_sh;
    logic [asoc_pkg::REM_W+1:0]        trial;
    logic                              root_bit;
    logic [VW-1:0]                     scaled;
    logic [VW-1:0]                     ram_rdata;
    logic [VW-1:0]                     old_speed;
    logic [TW-1:0]                     total_new;
    logic [PW-1:0]                     pos_inc;
    logic                              out_load;
    logic                              ram_we;

    assign accept    = sample_valid && !sample_stall;
    assign item_ok   = sample.bus_idle && (sample.raw_sample != '0);
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = asoc_pkg::reg_idx_t'(paddr[3:2]);
    assign pready    = 1'b1;

    assign cd_dec    = (countdown_reg != '0) ? countdown_reg - CDW'(1) : '0;
    assign calib_hit = !offset_done_reg && (cd_dec == '0);
    assign mean      = cprod_reg[CSH +: SW];
    assign off_lo    = (mean < offset_min_reg) ? offset_min_reg : mean;
    assign off_cl    = (off_lo > offset_max_reg) ? offset_max_reg : off_lo;

    assign rem_sh    = {rem_reg, rad_reg[asoc_pkg::RAD_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign root_bit  = (rem_sh >= trial);

    assign scaled    = sprod_reg[asoc_pkg::FRAC_W +: VW];

    assign old_speed = win_valid_reg[pos_reg] ? ram_rdata : '0;
    assign total_new = total_reg - TW'(old_speed) + TW'(speed_reg);
    assign pos_inc   = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);

    asoc_ram
    #(
        .WIDTH (VW),
        .DEPTH (WINDOW_LEN),
        .AW    (PW)
    )
    u_window_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (speed_reg),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // register read back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            asoc_pkg::REG_SPEED_SCALE: prdata = asoc_pkg::APB_DATA_W'(speed_scale_reg);
            asoc_pkg::REG_SPEED_BIAS:  prdata = asoc_pkg::APB_DATA_W'(speed_bias_reg);
            asoc_pkg::REG_OFFSET_MIN:  prdata = asoc_pkg::APB_DATA_W'(offset_min_reg);
            asoc_pkg::REG_OFFSET_MAX:  prdata = asoc_pkg::APB_DATA_W'(offset_max_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_scale_reg <= asoc_pkg::SPEED_SCALE_RST;
            speed_bias_reg  <= asoc_pkg::SPEED_BIAS_RST;
            offset_min_reg  <= asoc_pkg::OFFSET_MIN_RST;
            offset_max_reg  <= asoc_pkg::OFFSET_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                asoc_pkg::REG_SPEED_SCALE: speed_scale_reg <= pwdata[asoc_pkg::SCALE_W-1:0];
                asoc_pkg::REG_SPEED_BIAS:  speed_bias_reg  <= pwdata[VW-1:0];
                asoc_pkg::REG_OFFSET_MIN:  offset_min_reg  <= pwdata[SW-1:0];
                asoc_pkg::REG_OFFSET_MAX:  offset_max_reg  <= pwdata[SW-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asoc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sample_stall = 1'b1;
        out_load     = 1'b0;
        ram_we       = 1'b0;
        unique case (state_reg)
            asoc_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    state_next = item_ok ? asoc_pkg::ST_CALIB : asoc_pkg::ST_OUT;
                end
            end
            asoc_pkg::ST_CALIB:
            begin
                state_next = calib_hit ? asoc_pkg::ST_OFFSET : asoc_pkg::ST_PREP;
            end
            asoc_pkg::ST_OFFSET:
            begin
                state_next = asoc_pkg::ST_PREP;
            end
            asoc_pkg::ST_PREP:
            begin
                if (offset_done_reg && (raw_reg > zero_offset_reg))
                begin
                    state_next = asoc_pkg::ST_SQRT;
                end
                else
                begin
                    state_next = asoc_pkg::ST_ACC;
                end
            end
            asoc_pkg::ST_SQRT:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = asoc_pkg::ST_MUL;
                end
            end
            asoc_pkg::ST_MUL:
            begin
                state_next = asoc_pkg::ST_BIAS;
            end
            asoc_pkg::ST_BIAS:
            begin
                state_next = asoc_pkg::ST_ACC;
            end
            asoc_pkg::ST_ACC:
            begin
                ram_we     = 1'b1;
                state_next = asoc_pkg::ST_AVG;
            end
            asoc_pkg::ST_AVG:
            begin
                state_next = asoc_pkg::ST_OUT;
            end
            asoc_pkg::ST_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = asoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asoc_pkg::ST_IDLE;
            end
        endcase
    end

    // calibration and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg   <= CD_RST;
            calib_sum_reg   <= '0;
            zero_offset_reg <= '0;
            offset_done_reg <= 1'b0;
            pos_reg         <= '0;
            total_reg       <= '0;
            win_valid_reg   <= '0;
        end
        else
        begin
            if ((state_reg == asoc_pkg::ST_CALIB) && !offset_done_reg)
            begin
                countdown_reg <= cd_dec;
                if (!calib_hit && (cd_dec <= CD_SUM))
                begin
                    calib_sum_reg <= calib_sum_reg + CSW'(raw_reg);
                end
            end
            if (state_reg == asoc_pkg::ST_OFFSET)
            begin
                zero_offset_reg <= off_cl;
                offset_done_reg <= 1'b1;
            end
            if (state_reg == asoc_pkg::ST_ACC)
            begin
                total_reg              <= total_new;
                pos_reg                <= pos_inc;
                win_valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ok_reg <= item_ok;
            raw_reg     <= sample.raw_sample;
        end
        if (state_reg == asoc_pkg::ST_CALIB)
        begin
            cprod_reg <= CPW'(calib_sum_reg) * CPW'(CMUL);
        end
        if (state_reg == asoc_pkg::ST_PREP)
        begin
            rad_reg   <= {raw_reg - zero_offset_reg, {(asoc_pkg::RAD_W - SW){1'b0}}};
            rem_reg   <= '0;
            root_reg  <= '0;
            step_reg  <= '0;
            speed_reg <= '0;
        end
        if (state_reg == asoc_pkg::ST_SQRT)
        begin
            rad_reg  <= {rad_reg[asoc_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= root_bit ? asoc_pkg::REM_W'(rem_sh - trial)
                                 : asoc_pkg::REM_W'(rem_sh);
            root_reg <= {root_reg[asoc_pkg::ROOT_W-2:0], root_bit};
            step_reg <= step_reg + asoc_pkg::STEP_W'(1);
        end
        if (state_reg == asoc_pkg::ST_MUL)
        begin
            sprod_reg <= asoc_pkg::PROD_W'(speed_scale_reg) * asoc_pkg::PROD_W'(root_reg);
        end
        if (state_reg == asoc_pkg::ST_BIAS)
        begin
            speed_reg <= (scaled > speed_bias_reg) ? scaled - speed_bias_reg : '0;
        end
        if (state_reg == asoc_pkg::ST_AVG)
        begin
            wprod_reg <= WPW'(total_reg) * WPW'(WMUL);
        end
        if (out_load)
        begin
            result_reg.airspeed   <= item_ok_reg ? wprod_reg[WSH +: VW] : '0;
            result_reg.sample_ok  <= item_ok_reg;
            result_reg.calibrated <= offset_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_offset_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(offset_done_reg))
        else $error("offset_done cleared after calibration");

    a_countdown_live: assert property (@(posedge clk) disable iff (!rst_n)
        (!offset_done_reg && (state_reg != asoc_pkg::ST_OFFSET)) |-> (countdown_reg != '0))
        else $error("countdown reached zero without calibration");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("window position out of range");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == asoc_pkg::ST_OUT))
        else $error("result raised outside output state");

endmodule

// ----- dv/airspeed_offset_calib_sqrt_average_core_test.sv -----
// ----------------------------------------------------------------------------
// airspeed_offset_calib_sqrt_average_core_test
// self-checking bench for the airspeed offset calibration core: a bursty
// sample driver and a stalling result sink run against an in-bench model of
// offset calibration, q8 square root conversion and the moving average,
// with register phases written over the config port between traffic runs
// ----------------------------------------------------------------------------
module airspeed_offset_calib_sqrt_average_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 80;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            sample_valid = 1'b0;
    logic                            sample_stall;
    asoc_pkg::sample_t               sample       = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    asoc_pkg::result_t               result;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [asoc_pkg::APB_ADDR_W-1:0] paddr        = '0;
    logic [asoc_pkg::APB_DATA_W-1:0] pwdata       = '0;
    logic [asoc_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    // model configuration
    logic [asoc_pkg::SCALE_W-1:0]  scale_reg;
    logic [asoc_pkg::SPEED_W-1:0]  bias_reg;
    logic [asoc_pkg::SAMPLE_W-1:0] offset_lo;
    logic [asoc_pkg::SAMPLE_W-1:0] offset_hi;

    // model state
    int                            cal_left;
    logic [31:0]                   cal_sum;
    logic [asoc_pkg::SAMPLE_W-1:0] zero_off;
    logic                          offset_locked;
    logic [asoc_pkg::SPEED_W-1:0]  speed_hist [asoc_pkg::WINDOW_LEN_DEF];
    int                            hist_pos;
    logic [31:0]                   hist_total;

    asoc_pkg::sample_t sample_feed [$];
    asoc_pkg::result_t speed_due [$];

    int          error_count = 0;
    int          idle_cycles = 0;
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          stall_age   = 0;
    logic [15:0] stall_pat   = '0;
    logic        in_taken    = 1'b0;

    airspeed_offset_calib_sqrt_average_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [15:0] floor_sqrt(logic [31:0] v);
        logic [15:0] root;
        root = '0;
        for (int i = 15; i >= 0; i--)
        begin
            root[i] = 1'b1;
            if (32'(root) * 32'(root) > v)
                root[i] = 1'b0;
        end
        return root;
    endfunction

    function automatic asoc_pkg::result_t convert_sample(asoc_pkg::sample_t s);
        asoc_pkg::result_t            r;
        logic [31:0]                  mean;
        logic [31:0]                  prod;
        logic [asoc_pkg::SPEED_W-1:0] raw_speed;
        logic [asoc_pkg::SPEED_W-1:0] speed;
        logic [15:0]                  root;
        r            = '0;
        speed        = '0;
        r.calibrated = offset_locked;
        if (!s.bus_idle || s.raw_sample == '0)
            return r;
        if (!offset_locked)
        begin
            if (cal_left > 0)
                cal_left--;
            if (cal_left == 0)
            begin
                mean = (cal_sum / asoc_pkg::CALIB_COUNT_DEF) & 32'hFFFF;
                if (mean < 32'(offset_lo))
                    mean = 32'(offset_lo);
                if (mean > 32'(offset_hi))
                    mean = 32'(offset_hi);
                zero_off      = mean[15:0];
                offset_locked = 1'b1;
            end
            else if (cal_left <= asoc_pkg::CALIB_COUNT_DEF)
                cal_sum += 32'(s.raw_sample);
        end
        if (offset_locked && s.raw_sample > zero_off)
        begin
            root      = floor_sqrt({s.raw_sample - zero_off, 16'h0000});
            prod      = 32'(scale_reg) * 32'(root);
            raw_speed = prod[asoc_pkg::FRAC_W +: asoc_pkg::SPEED_W];
            speed     = (raw_speed > bias_reg) ? raw_speed - bias_reg : '0;
        end
        hist_total           = hist_total - 32'(speed_hist[hist_pos]) + 32'(speed);
        speed_hist[hist_pos] = speed;
        hist_pos             = (hist_pos + 1) % asoc_pkg::WINDOW_LEN_DEF;
        r.airspeed           = asoc_pkg::SPEED_W'(hist_total / asoc_pkg::WINDOW_LEN_DEF);
        r.sample_ok          = 1'b1;
        r.calibrated         = offset_locked;
        return r;
    endfunction

    function automatic asoc_pkg::sample_t random_sample();
        asoc_pkg::sample_t s;
        int                near;
        s.bus_idle = 1'b1;
        case ($urandom_range(0, 9))
            0:
            begin
                s.bus_idle   = 1'b0;
                s.raw_sample = 16'($urandom);
            end
            1: s.raw_sample = '0;
            2: s.raw_sample = 16'hFFFF;
            3, 4: s.raw_sample = 16'($urandom_range(1, 65535));
            default:
            begin
                near = int'(offset_locked ? zero_off : 16'd1650)
                       + int'($urandom_range(0, 600)) - 40;
                if (near < 1)
                    near = 1;
                if (near > 65535)
                    near = 65535;
                s.raw_sample = near[15:0];
            end
        endcase
        return s;
    endfunction

    task automatic set_register(asoc_pkg::reg_idx_t idx, logic [31:0] low_value);
        logic [31:0] mask;
        logic [31:0] value;
        logic [31:0] readback;
        case (idx)
            asoc_pkg::REG_SPEED_SCALE: mask = 32'h0000_03FF;
            asoc_pkg::REG_SPEED_BIAS:  mask = 32'h0003_FFFF;
            default:                   mask = 32'h0000_FFFF;
        endcase
        value = (32'($urandom) & ~mask) | (low_value & mask);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            asoc_pkg::REG_SPEED_SCALE: scale_reg = value[asoc_pkg::SCALE_W-1:0];
            asoc_pkg::REG_SPEED_BIAS:  bias_reg  = value[asoc_pkg::SPEED_W-1:0];
            asoc_pkg::REG_OFFSET_MIN:  offset_lo = value[asoc_pkg::SAMPLE_W-1:0];
            asoc_pkg::REG_OFFSET_MAX:  offset_hi = value[asoc_pkg::SAMPLE_W-1:0];
        endcase
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== (value & mask))
            report_mismatch($sformatf("register %s readback", idx.name()), readback,
                            value & mask);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sample_feed.size() != 0 || sample_valid || speed_due.size() != 0);
    endtask

    // sample driver
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_valid <= 1'b0;
        else if (!sample_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left     <= gap_left - 1;
                sample_valid <= 1'b0;
            end
            else if (sample_feed.size() > 0)
            begin
                sample       <= sample_feed.pop_front();
                sample_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                sample_valid <= 1'b0;
        end
    end

    // result sink stall pattern
    always @(negedge clk)
    begin
        logic [15:0] pick;
        pick = '0;
        stall_age <= stall_age + 1;
        if (stall_age % 48 == 0)
        begin
            case ($urandom_range(0, 3))
                0: pick = '0;
                1: pick = 16'($urandom);
                2: pick = 16'($urandom & $urandom);
                default: pick = 16'($urandom | $urandom);
            endcase
            pick[$urandom_range(0, 15)] = 1'b0;
            stall_pat    <= pick;
            result_stall <= pick[0];
        end
        else
            result_stall <= stall_pat[stall_age % 16];
    end

    // monitor
    always @(posedge clk)
    begin
        asoc_pkg::result_t want;
        in_taken <= rst_n && sample_valid && !sample_stall;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
                speed_due.push_back(convert_sample(sample));
            if (result_valid && !result_stall)
            begin
                if (speed_due.size() == 0)
                    report_mismatch("transaction with no expectation", 32'(result), 32'd0);
                else
                begin
                    want = speed_due.pop_front();
                    if (result.airspeed !== want.airspeed)
                        report_mismatch("airspeed", 32'(result.airspeed),
                                        32'(want.airspeed));
                    if (result.sample_ok !== want.sample_ok)
                        report_mismatch("sample_ok", 32'(result.sample_ok),
                                        32'(want.sample_ok));
                    if (result.calibrated !== want.calibrated)
                        report_mismatch("calibrated", 32'(result.calibrated),
                                        32'(want.calibrated));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        asoc_pkg::sample_t s;
        int                valid_sent;
        valid_sent    = 0;
        scale_reg     = asoc_pkg::SPEED_SCALE_RST;
        bias_reg      = asoc_pkg::SPEED_BIAS_RST;
        offset_lo     = asoc_pkg::OFFSET_MIN_RST;
        offset_hi     = asoc_pkg::OFFSET_MAX_RST;
        cal_left      = asoc_pkg::SKIP_COUNT_DEF + asoc_pkg::CALIB_COUNT_DEF;
        cal_sum       = '0;
        zero_off      = '0;
        offset_locked = 1'b0;
        hist_pos      = 0;
        hist_total    = '0;
        for (int i = 0; i < asoc_pkg::WINDOW_LEN_DEF; i++)
            speed_hist[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // crossed clamp bounds: the upper bound decides the offset
        set_register(asoc_pkg::REG_SPEED_SCALE, 32'h3FF);
        set_register(asoc_pkg::REG_SPEED_BIAS, 32'h0);
        set_register(asoc_pkg::REG_OFFSET_MIN, 32'hFFFF);
        set_register(asoc_pkg::REG_OFFSET_MAX, $urandom_range(1000, 3000));

        // invalid and extreme samples before calibration
        sample_feed.push_back('{1'b0, 16'h0000});
        sample_feed.push_back('{1'b0, 16'hFFFF});
        sample_feed.push_back('{1'b1, 16'h0000});
        sample_feed.push_back('{1'b0, 16'h0001});
        sample_feed.push_back('{1'b1, 16'hFFFF});
        sample_feed.push_back('{1'b1, 16'h0001});
        sample_feed.push_back('{1'b1, 16'h5555});
        sample_feed.push_back('{1'b1, 16'hAAAA});
        valid_sent = 4;

        // skip, sum and calibrating sample
        while (valid_sent < asoc_pkg::SKIP_COUNT_DEF + asoc_pkg::CALIB_COUNT_DEF)
        begin
            s = random_sample();
            if (s.bus_idle && s.raw_sample != '0)
                valid_sent++;
            sample_feed.push_back(s);
        end
        wait_drained();

        // around the offset once calibrated
        sample_feed.push_back('{1'b1, zero_off});
        sample_feed.push_back('{1'b1, zero_off - 16'd1});
        sample_feed.push_back('{1'b1, zero_off + 16'd1});
        sample_feed.push_back('{1'b1, 16'hFFFF});
        sample_feed.push_back('{1'b0, 16'hFFFF});
        sample_feed.push_back('{1'b1, 16'h0000});
        wait_drained();

        // bias above any scaled root
        set_register(asoc_pkg::REG_SPEED_BIAS, 32'h3FFFF);
        sample_feed.push_back('{1'b1, 16'hFFFF});
        sample_feed.push_back('{1'b1, zero_off + 16'd500});
        sample_feed.push_back('{1'b1, 16'hFFFF});
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    set_register(asoc_pkg::REG_SPEED_SCALE, 32'(asoc_pkg::SPEED_SCALE_RST));
                    set_register(asoc_pkg::REG_SPEED_BIAS, 32'h0);
                    set_register(asoc_pkg::REG_OFFSET_MIN, 32'h0);
                    set_register(asoc_pkg::REG_OFFSET_MAX, 32'hFFFF);
                end
                1:
                begin
                    set_register(asoc_pkg::REG_SPEED_SCALE, 32'h0);
                    set_register(asoc_pkg::REG_SPEED_BIAS, $urandom_range(0, 262143));
                end
                2:
                begin
                    set_register(asoc_pkg::REG_SPEED_SCALE, 32'h3FF);
                    set_register(asoc_pkg::REG_SPEED_BIAS, $urandom_range(0, 2000));
                end
                3:
                begin
                    set_register(asoc_pkg::REG_SPEED_SCALE, $urandom_range(0, 1023));
                    set_register(asoc_pkg::REG_SPEED_BIAS, $urandom_range(0, 100000));
                end
                default:
                begin
                    set_register(asoc_pkg::REG_SPEED_SCALE, $urandom_range(0, 1023));
                    set_register(asoc_pkg::REG_SPEED_BIAS, $urandom_range(0, 262143));
                    set_register(asoc_pkg::REG_OFFSET_MIN, $urandom_range(0, 65535));
                    set_register(asoc_pkg::REG_OFFSET_MAX, $urandom_range(0, 65535));
                end
            endcase
            for (int i = 0; i < PHASE_LEN; i++)
                sample_feed.push_back(random_sample());
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/asoc_pkg.sv
rtl/core/asoc_ram.sv
rtl/core/airspeed_offset_calib_sqrt_average_core.sv
dv/airspeed_offset_calib_sqrt_average_core_test.sv
